@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/frd_pkg.sv @@
// Shared types and constants for the fraction to recurring decimal core.
package frd_pkg;

  localparam int VAL_W          = 31;
  localparam int DIG_W          = 4;
  localparam int COUNT_W        = 6;
  localparam int MAX_DIGITS_DEF = 63;
  localparam int INT_STEPS      = VAL_W;
  localparam int DIG_STEPS      = DIG_W;
  localparam int CNT_W          = $clog2(INT_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVI,
    S_CHECK,
    S_DIVD,
    S_SEARCH,
    S_EMITI,
    S_EMITD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic int_fin;
    logic dig_init;
    logic dig_fin;
    logic search;
    logic set_cycle;
    logic emit_err;
    logic emit_int;
    logic emit_dig;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic rem_zero;
    logic at_limit;
    logic hit;
    logic miss_end;
    logic pa_zero;
    logic emit_last;
  } sts_t;

endpackage

@@ design/fraction_recurring_decimal_core.sv @@
// Fraction to recurring decimal core: one request at a time, busy high while at work.
// A run of D digits gives 1 + D results on consecutive cycles. The work is the 31-step
// integer divide, 4 steps per digit, and the remainder search that reads one stored
// entry per cycle from the single RAM port.
// A zero denominator answers with one result the cycle after the request.
// Synchronous reset returns to idle; store contents are not cleared.
module fraction_recurring_decimal_core #(
  parameter int MAX_DIGITS = frd_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [frd_pkg::VAL_W-1:0]   numerator,
  input  logic [frd_pkg::VAL_W-1:0]   denominator,
  output logic                        strobe,
  output logic [frd_pkg::VAL_W-1:0]   value,
  output logic                        is_integer_part,
  output logic                        repeat_start,
  output logic                        repeats,
  output logic [frd_pkg::COUNT_W-1:0] digit_count,
  output logic                        last
);
  import frd_pkg::*;

  `include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  frd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  frd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .numerator       (numerator),
    .denominator     (denominator),
    .strobe          (strobe),
    .value           (value),
    .is_integer_part (is_integer_part),
    .repeat_start    (repeat_start),
    .repeats         (repeats),
    .digit_count     (digit_count),
    .last            (last)
  );

  // results of one run come out back to back
  `ASSERT_NEXT(a_run_contiguous, clk, rst, strobe && !last, strobe, "result run broken")
  // a valid request always starts work
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy && (denominator != '0), busy,
    "request not taken")
  // integer part opens a run: never in the middle of another one
  `ASSERT_IMPL(a_int_first, clk, rst, strobe && is_integer_part,
    !$past(strobe) || $past(last), "integer part inside a run")
  // digit count only shows on the last result
  `ASSERT_IMPL(a_count_last, clk, rst, strobe && !last, digit_count == '0,
    "digit count before last")

endmodule

@@ design/frd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module frd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/frd_ctrl.sv @@
// Controller state machine: sequences divides, remainder search and result output.
module frd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  frd_pkg::sts_t sts,
  output frd_pkg::cmd_t cmd
);
  import frd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start && !sts.den_zero) state_next = S_DIVI;
      end
      S_DIVI: begin
        if (sts.div_done) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.rem_zero || sts.at_limit) state_next = S_EMITI;
        else                              state_next = S_DIVD;
      end
      S_DIVD: begin
        if (sts.div_done) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        priority if (sts.hit)      state_next = S_EMITI;
        else if (sts.miss_end)     state_next = S_CHECK;
        else                       state_next = S_SEARCH;
      end
      S_EMITI: begin
        if (sts.pa_zero) state_next = S_IDLE;
        else             state_next = S_EMITD;
      end
      S_EMITD: begin
        if (sts.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load     = start && !sts.den_zero;
        cmd.emit_err = start && sts.den_zero;
      end
      S_DIVI: begin
        cmd.int_fin  = sts.div_done;
        cmd.div_step = !sts.div_done;
      end
      S_CHECK: begin
        cmd.dig_init = !(sts.rem_zero || sts.at_limit);
      end
      S_DIVD: begin
        cmd.dig_fin  = sts.div_done;
        cmd.div_step = !sts.div_done;
      end
      S_SEARCH: begin
        cmd.search    = 1'b1;
        cmd.set_cycle = sts.hit;
      end
      S_EMITI: cmd.emit_int = 1'b1;
      S_EMITD: cmd.emit_dig = 1'b1;
      default: cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ design/frd_datapath.sv @@
// Datapath: shared restoring divider, remainder/digit store and result registers.
module frd_datapath #(
  parameter int MAX_DIGITS = frd_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  frd_pkg::cmd_t               cmd,
  output frd_pkg::sts_t               sts,
  input  logic [frd_pkg::VAL_W-1:0]   numerator,
  input  logic [frd_pkg::VAL_W-1:0]   denominator,
  output logic                        strobe,
  output logic [frd_pkg::VAL_W-1:0]   value,
  output logic                        is_integer_part,
  output logic                        repeat_start,
  output logic                        repeats,
  output logic [frd_pkg::COUNT_W-1:0] digit_count,
  output logic                        last
);
  import frd_pkg::*;

  localparam int DEPTH = MAX_DIGITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = DIG_W + VAL_W;

  logic [VAL_W-1:0] den_r;
  logic [VAL_W-1:0] quot;
  logic [VAL_W-1:0] pr;
  logic [VAL_W-1:0] sh;
  logic [CNT_W-1:0] cnt;
  logic [VAL_W-1:0] cur_rem;
  logic [AW-1:0]    pa;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    rd_idx;
  logic [AW-1:0]    pos;
  logic             rd_pend;
  logic             cycle;

  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   trial_sub;
  logic             trial_ge;
  logic [VAL_W+3:0] rem10;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [EW-1:0]    wdata;
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    rdata;
  logic [DIG_W-1:0] rd_digit;
  logic [VAL_W-1:0] rd_rem;
  logic             more_to_read;

  // one restoring-division step: shift next dividend bit into partial remainder
  assign trial     = {pr, sh[VAL_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign trial_ge  = (trial >= {1'b0, den_r});

  assign rem10 = ({4'b0, cur_rem} << 3) + ({4'b0, cur_rem} << 1);

  assign more_to_read = (idx < pa);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      den_r <= denominator;
      pr    <= '0;
      sh    <= numerator;
      cnt   <= CNT_W'(INT_STEPS);
    end else if (cmd.dig_init) begin
      // rem*10 < 10*den, so its top bits already sit below den
      pr  <= rem10[VAL_W+3:4];
      sh  <= {rem10[3:0], (VAL_W-4)'(0)};
      cnt <= CNT_W'(DIG_STEPS);
    end else if (cmd.div_step) begin
      pr  <= trial_ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
      sh  <= {sh[VAL_W-2:0], trial_ge};
      cnt <= cnt - CNT_W'(1);
    end

    if (cmd.int_fin) begin
      quot    <= sh;
      cur_rem <= pr;
      pa      <= '0;
    end else if (cmd.dig_fin) begin
      cur_rem <= pr;
      pa      <= pa + AW'(1);
    end

    if (cmd.dig_fin) begin
      idx <= '0;
    end else if (cmd.search && more_to_read) begin
      idx <= idx + AW'(1);
    end

    if (cmd.set_cycle) begin
      pos <= rd_idx;
    end

    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      cycle   <= 1'b0;
    end else begin
      rd_pend <= cmd.search && more_to_read;
      if (cmd.int_fin) begin
        cycle <= 1'b0;
      end else if (cmd.set_cycle) begin
        cycle <= 1'b1;
      end
    end
  end

  always_comb begin
    priority if (cmd.emit_int) rd_addr = AW'(1);
    else if (cmd.emit_dig)     rd_addr = rd_idx + AW'(1);
    else                       rd_addr = idx;
  end

  assign we    = cmd.int_fin | cmd.dig_fin;
  assign waddr = cmd.int_fin ? '0 : pa + AW'(1);
  assign wdata = cmd.int_fin ? {DIG_W'(0), pr} : {sh[DIG_W-1:0], pr};

  frd_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rd_digit = rdata[EW-1:VAL_W];
  assign rd_rem   = rdata[VAL_W-1:0];

  always_comb begin
    sts           = '0;
    sts.den_zero  = (denominator == '0);
    sts.div_done  = (cnt == '0);
    sts.rem_zero  = (cur_rem == '0);
    sts.at_limit  = (pa == AW'(MAX_DIGITS));
    sts.hit       = rd_pend && (rd_rem == cur_rem);
    sts.miss_end  = rd_pend && (rd_rem != cur_rem) && (rd_idx == pa - AW'(1));
    sts.pa_zero   = (pa == '0);
    sts.emit_last = (rd_idx == pa);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_err | cmd.emit_int | cmd.emit_dig;
    end
  end

  // result registers hold between runs
  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      value           <= '1;
      is_integer_part <= 1'b1;
      repeat_start    <= 1'b0;
      repeats         <= 1'b0;
      digit_count     <= '0;
      last            <= 1'b1;
    end else if (cmd.emit_int) begin
      value           <= quot;
      is_integer_part <= 1'b1;
      repeat_start    <= 1'b0;
      repeats         <= cycle;
      digit_count     <= '0;
      last            <= (pa == '0);
    end else if (cmd.emit_dig) begin
      value           <= VAL_W'(rd_digit);
      is_integer_part <= 1'b0;
      repeat_start    <= cycle && (rd_idx == pos + AW'(1));
      repeats         <= cycle;
      digit_count     <= (rd_idx == pa) ? COUNT_W'(pa) : '0;
      last            <= (rd_idx == pa);
    end
  end

endmodule
